// ===== src/prdc_pkg.sv =====
package prdc_pkg;

  localparam int unsigned SYMBOLS = 4096;
  localparam int unsigned AddrW = $clog2(SYMBOLS);
  localparam int unsigned SymW = 12;
  localparam int unsigned CntW = 32;
  localparam int unsigned HistW = 2 * CntW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MaxRes = 2;
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW = $clog2(OutDepth);
  localparam int unsigned OutCntW = $clog2(OutDepth + 1);

  typedef logic [SymW-1:0] sym_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic signed [CntW-1:0] delta_t;
  typedef logic [HistW-1:0] hist_t;
  typedef logic [1:0] nres_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAIR_FIRST,
    CFG_PAIR_SECOND,
    CFG_NEW_SYMBOL
  } cfg_idx_e;

  typedef enum logic {
    CMD_STREAM,
    CMD_READ
  } cmd_e;

  typedef enum logic {
    KIND_SYMBOL,
    KIND_DELTA
  } kind_e;

  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_UPDATE,
    HOP_READ_CLEAR
  } hop_e;

  // one accepted request as issued to the histogram stage
  typedef struct packed {
    logic  valid;
    kind_e kind;
    hop_e  op_a;
    addr_t addr_a;
    hop_e  op_b;
    addr_t addr_b;
    nres_t n;
    sym_t  sym0;
    logic  last0;
    sym_t  sym1;
    logic  last1;
    cnt_t  repl;
  } s0_req_t;

  typedef struct packed {
    kind_e  kind;
    sym_t   sym;
    logic   last;
    delta_t d_left_new;
    delta_t d_new_right;
    delta_t d_left_first;
    delta_t d_second_right;
    cnt_t   repl;
  } res_t;

  typedef struct packed {
    nres_t n;
    res_t  r0;
    res_t  r1;
  } push_t;

  typedef struct packed {
    logic  clr_busy;
    nres_t s1_n;
  } hist_stat_t;

  function automatic logic in_range(sym_t s);
    return 32'(s) < SYMBOLS;
  endfunction

  function automatic addr_t to_addr(sym_t s);
    return AddrW'(s);
  endfunction

endpackage

// ===== src/prdc_in_if.sv =====
interface prdc_in_if;
  import prdc_pkg::*;

  logic valid;
  logic ready;
  logic cmd;
  sym_t symbol;
  logic last;

  modport source(output valid, cmd, symbol, last, input ready);
  modport sink(input valid, cmd, symbol, last, output ready);
endinterface

// ===== src/prdc_out_if.sv =====
interface prdc_out_if;
  import prdc_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  sym_t   out_symbol;
  logic   out_last;
  delta_t delta_left_new;
  delta_t delta_new_right;
  delta_t delta_left_first;
  delta_t delta_second_right;
  cnt_t   replacements;

  modport source(output valid, kind, out_symbol, out_last, delta_left_new, delta_new_right,
                 delta_left_first, delta_second_right, replacements, input ready);
  modport sink(input valid, kind, out_symbol, out_last, delta_left_new, delta_new_right,
               delta_left_first, delta_second_right, replacements, output ready);
endinterface

// ===== src/prdc_ram.sv =====
module prdc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/prdc_ctrl.sv =====
module prdc_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [prdc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  prdc_pkg::sym_t                       cfg_data_i,
  input  logic                                 accept_i,
  input  logic                                 cmd_i,
  input  prdc_pkg::sym_t                       symbol_i,
  input  logic                                 last_i,
  output prdc_pkg::s0_req_t                    req_o
);
  import prdc_pkg::*;

  sym_t pair_first_q, pair_second_q, new_symbol_q;
  sym_t prev_out_q, prev_out_d;
  logic prev_valid_q, prev_valid_d;
  sym_t held_q, held_d;
  logic held_valid_q, held_valid_d;
  logic await_q, await_d;
  cnt_t repl_q, repl_d;
  cnt_t repl_base;
  logic match;

  assign repl_base = (!prev_valid_q && !held_valid_q) ? '0 : repl_q;
  assign match = held_valid_q && (held_q == pair_first_q) && (symbol_i == pair_second_q);

  always_comb begin
    prev_out_d   = prev_out_q;
    prev_valid_d = prev_valid_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    await_d      = await_q;
    repl_d       = repl_q;
    req_o        = '0;
    req_o.kind   = KIND_SYMBOL;
    req_o.op_a   = HOP_NONE;
    req_o.op_b   = HOP_NONE;
    if (accept_i) begin
      req_o.valid = 1'b1;
      if (cmd_e'(cmd_i) == CMD_READ) begin
        req_o.kind   = KIND_DELTA;
        req_o.addr_a = to_addr(symbol_i);
        req_o.addr_b = to_addr(symbol_i);
        if (in_range(symbol_i)) begin
          req_o.op_a = HOP_READ_CLEAR;
          req_o.op_b = HOP_READ_CLEAR;
        end
        req_o.n    = 2'd1;
        req_o.sym0 = symbol_i;
        req_o.repl = repl_q;
      end else begin
        repl_d = repl_base;
        // right neighbour of the previous replacement
        req_o.addr_b = to_addr(symbol_i);
        if (await_q && in_range(symbol_i)) begin
          req_o.op_b = HOP_UPDATE;
        end
        await_d = 1'b0;
        req_o.addr_a = to_addr(prev_out_q);
        if (match) begin
          if (prev_valid_q && in_range(prev_out_q)) begin
            req_o.op_a = HOP_UPDATE;
          end
          repl_d       = repl_base + cnt_t'(1);
          held_valid_d = 1'b0;
          prev_out_d   = new_symbol_q;
          prev_valid_d = 1'b1;
          await_d      = !last_i;
          req_o.n      = 2'd1;
          req_o.sym0   = new_symbol_q;
          req_o.last0  = last_i;
        end else begin
          if (held_valid_q) begin
            req_o.sym0   = held_q;
            prev_out_d   = held_q;
            prev_valid_d = 1'b1;
            if (last_i) begin
              req_o.n     = 2'd2;
              req_o.sym1  = symbol_i;
              req_o.last1 = 1'b1;
            end else begin
              req_o.n = 2'd1;
            end
          end else if (last_i) begin
            req_o.n     = 2'd1;
            req_o.sym0  = symbol_i;
            req_o.last0 = 1'b1;
          end
          held_d       = symbol_i;
          held_valid_d = 1'b1;
        end
        req_o.repl = repl_d;
        if (last_i) begin
          prev_valid_d = 1'b0;
          held_valid_d = 1'b0;
          await_d      = 1'b0;
          prev_out_d   = '0;
          held_d       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_first_q  <= '0;
      pair_second_q <= '0;
      new_symbol_q  <= '0;
      prev_out_q    <= '0;
      prev_valid_q  <= 1'b0;
      held_q        <= '0;
      held_valid_q  <= 1'b0;
      await_q       <= 1'b0;
      repl_q        <= '0;
    end else begin
      prev_out_q   <= prev_out_d;
      prev_valid_q <= prev_valid_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      await_q      <= await_d;
      repl_q       <= repl_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PAIR_FIRST:  pair_first_q  <= cfg_data_i;
          CFG_PAIR_SECOND: pair_second_q <= cfg_data_i;
          CFG_NEW_SYMBOL:  new_symbol_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/prdc_hist.sv =====
module prdc_hist (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  prdc_pkg::s0_req_t    req_i,
  output prdc_pkg::push_t      push_o,
  output prdc_pkg::hist_stat_t stat_o
);
  import prdc_pkg::*;

  // memory a: {left_new, left_first}, memory b: {new_right, second_right}
  s0_req_t s1_q;
  logic    clr_q;
  addr_t   clr_addr_q;
  logic    fa_valid_q, fb_valid_q;
  addr_t   fa_addr_q, fb_addr_q;
  hist_t   fa_data_q, fb_data_q;

  hist_t rdata_a, rdata_b, cur_a, cur_b, upd_a, upd_b;
  logic  we_a, we_b;
  addr_t waddr_a, waddr_b;
  hist_t wdata_a, wdata_b;

  prdc_ram #(.Width(HistW), .Depth(SYMBOLS)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(waddr_a),
    .wdata_i(wdata_a),
    .re_i   (req_i.valid),
    .raddr_i(req_i.addr_a),
    .rdata_o(rdata_a)
  );

  prdc_ram #(.Width(HistW), .Depth(SYMBOLS)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(waddr_b),
    .wdata_i(wdata_b),
    .re_i   (req_i.valid),
    .raddr_i(req_i.addr_b),
    .rdata_o(rdata_b)
  );

  // the write of the previous cycle is not yet visible in the read data
  assign cur_a = (fa_valid_q && fa_addr_q == s1_q.addr_a) ? fa_data_q : rdata_a;
  assign cur_b = (fb_valid_q && fb_addr_q == s1_q.addr_b) ? fb_data_q : rdata_b;

  always_comb begin
    upd_a = '0;
    upd_b = '0;
    if (s1_q.op_a == HOP_UPDATE) begin
      upd_a = {cur_a[HistW-1:CntW] + cnt_t'(1), cur_a[CntW-1:0] - cnt_t'(1)};
    end
    if (s1_q.op_b == HOP_UPDATE) begin
      upd_b = {cur_b[HistW-1:CntW] + cnt_t'(1), cur_b[CntW-1:0] - cnt_t'(1)};
    end
  end

  always_comb begin
    if (clr_q) begin
      we_a    = 1'b1;
      we_b    = 1'b1;
      waddr_a = clr_addr_q;
      waddr_b = clr_addr_q;
      wdata_a = '0;
      wdata_b = '0;
    end else begin
      we_a    = s1_q.valid && (s1_q.op_a != HOP_NONE);
      we_b    = s1_q.valid && (s1_q.op_b != HOP_NONE);
      waddr_a = s1_q.addr_a;
      waddr_b = s1_q.addr_b;
      wdata_a = upd_a;
      wdata_b = upd_b;
    end
  end

  always_comb begin
    push_o           = '0;
    push_o.n         = s1_q.valid ? s1_q.n : 2'd0;
    push_o.r0.kind   = s1_q.kind;
    push_o.r0.sym    = s1_q.sym0;
    push_o.r0.last   = s1_q.last0;
    push_o.r0.repl   = s1_q.repl;
    push_o.r1.kind   = KIND_SYMBOL;
    push_o.r1.sym    = s1_q.sym1;
    push_o.r1.last   = s1_q.last1;
    push_o.r1.repl   = s1_q.repl;
    if (s1_q.op_a == HOP_READ_CLEAR) begin
      push_o.r0.d_left_new   = $signed(cur_a[HistW-1:CntW]);
      push_o.r0.d_left_first = $signed(cur_a[CntW-1:0]);
    end
    if (s1_q.op_b == HOP_READ_CLEAR) begin
      push_o.r0.d_new_right    = $signed(cur_b[HistW-1:CntW]);
      push_o.r0.d_second_right = $signed(cur_b[CntW-1:0]);
    end
  end

  assign stat_o.clr_busy = clr_q;
  assign stat_o.s1_n     = s1_q.valid ? s1_q.n : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      fa_valid_q <= 1'b0;
      fb_valid_q <= 1'b0;
    end else begin
      s1_q <= req_i;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + addr_t'(1);
        if (clr_addr_q == addr_t'(SYMBOLS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (we_a) begin
        fa_valid_q <= 1'b1;
      end
      if (we_b) begin
        fb_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      fa_addr_q <= waddr_a;
      fa_data_q <= wdata_a;
    end
    if (we_b) begin
      fb_addr_q <= waddr_b;
      fb_data_q <= wdata_b;
    end
  end

endmodule

// ===== src/prdc_outq.sv =====
module prdc_outq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prdc_pkg::push_t               push_i,
  prdc_out_if.source                    res_o,
  output logic [prdc_pkg::OutCntW-1:0]  level_o
);
  import prdc_pkg::*;

  res_t                mem_q [OutDepth];
  logic [OutPtrW-1:0]  rd_q, rd_d, wr_q, wr_d;
  logic [OutCntW-1:0]  cnt_q, cnt_d;
  logic                pop;
  res_t                head;

  assign head = mem_q[rd_q];
  assign pop  = res_o.valid && res_o.ready;

  assign rd_d  = rd_q + OutPtrW'(pop);
  assign wr_d  = wr_q + OutPtrW'(push_i.n);
  assign cnt_d = cnt_q + OutCntW'(push_i.n) - OutCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + OutPtrW'(1)] <= push_i.r1;
    end
  end

  assign res_o.valid              = (cnt_q != '0);
  assign res_o.kind               = head.kind;
  assign res_o.out_symbol         = head.sym;
  assign res_o.out_last           = head.last;
  assign res_o.delta_left_new     = head.d_left_new;
  assign res_o.delta_new_right    = head.d_new_right;
  assign res_o.delta_left_first   = head.d_left_first;
  assign res_o.delta_second_right = head.d_second_right;
  assign res_o.replacements       = head.repl;
  assign level_o                  = cnt_q;

endmodule

// ===== src/pair_replace_delta_counter_unit.sv =====
// pair replacement with neighbour delta histograms
// req_i carries requests: cmd stream feeds one grammar symbol (last ends the
// stream), cmd read returns the four histogram entries at symbol and clears them.
// res_o carries results: rewritten stream symbols (kind 0) or readouts (kind 1),
// each with the running replacement count. a request gives zero, one or two results.
// pair_first, pair_second and new_symbol are set through cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle.
// a result is registered with its request in the histogram stage, then pushed into the
// output queue, from which res_o offers it. throughput: one request per cycle while
// req_i.ready is high; a request that gives two results can hold req_i.ready low while
// the queue drains. each request does at most one read-modify-write in each of the two
// histogram memories (read, update, write back the next cycle, with forwarding).
// output results sit in a four-entry queue; req_i.ready drops when the queue plus
// the results in flight could overflow it, so a stalled receiver backs up into req_i.
// reset: the stream state, count and configuration clear at once, then a clearing
// pass writes zero to all 4096 histogram entries, one per cycle; req_i.ready stays
// low until that pass is done.
module pair_replace_delta_counter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [prdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  prdc_pkg::sym_t                cfg_data_i,
  prdc_in_if.sink                       req_i,
  prdc_out_if.source                    res_o
);
  import prdc_pkg::*;

  s0_req_t              req;
  push_t                push;
  hist_stat_t           stat;
  logic [OutCntW-1:0]   level;
  logic                 accept;

  // room for the results in flight plus the largest result count of a new request
  assign req_i.ready = !stat.clr_busy
                       && ((level + OutCntW'(stat.s1_n)) <= OutCntW'(OutDepth - MaxRes));
  assign accept      = req_i.valid && req_i.ready;

  prdc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .accept_i  (accept),
    .cmd_i     (req_i.cmd),
    .symbol_i  (req_i.symbol),
    .last_i    (req_i.last),
    .req_o     (req)
  );

  prdc_hist u_hist (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .push_o(push),
    .stat_o(stat)
  );

  prdc_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_o  (res_o),
    .level_o(level)
  );

endmodule

// ===== src/prdc_chk.sv =====
module prdc_chk (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    out_kind_i,
  input prdc_pkg::sym_t          out_symbol_i,
  input logic                    out_last_i,
  input prdc_pkg::delta_t        d_left_new_i,
  input prdc_pkg::delta_t        d_new_right_i,
  input prdc_pkg::delta_t        d_left_first_i,
  input prdc_pkg::delta_t        d_second_right_i,
  input prdc_pkg::cnt_t          repl_i
);
  import prdc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_symbol_i)
      && $stable(out_kind_i) && $stable(out_last_i) && $stable(repl_i))
    else $error("stalled result changed");

  a_sym_no_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_e'(out_kind_i) == KIND_SYMBOL) |->
      d_left_new_i == '0 && d_new_right_i == '0
      && d_left_first_i == '0 && d_second_right_i == '0)
    else $error("stream symbol result carries deltas");

  a_read_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_e'(out_kind_i) == KIND_DELTA) |-> !out_last_i)
    else $error("readout marked last");

  // histogram clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i && !out_valid_i)
    else $error("request taken during clearing pass");

endmodule

bind pair_replace_delta_counter_unit prdc_chk u_prdc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .out_kind_i      (res_o.kind),
  .out_symbol_i    (res_o.out_symbol),
  .out_last_i      (res_o.out_last),
  .d_left_new_i    (res_o.delta_left_new),
  .d_new_right_i   (res_o.delta_new_right),
  .d_left_first_i  (res_o.delta_left_first),
  .d_second_right_i(res_o.delta_second_right),
  .repl_i          (res_o.replacements)
);
